// File: rtl/core/v3n_pkg.sv
// Package for vec3_normalize: widths, stage counts and the records that
// travel along the square-root and divider cell rows. No dependencies.
package v3n_pkg;

	localparam int COMP_WIDTH = 32;
	localparam int SUM_WIDTH  = 2 * COMP_WIDTH;
	localparam int ROOT_BITS  = COMP_WIDTH;
	localparam int QUO_BITS   = 31;
	localparam int MAG_WIDTH  = 33;
	localparam int LANES      = 3;
	localparam int PRE_STAGES = 3;
	localparam int PIPE_DEPTH = PRE_STAGES + ROOT_BITS + QUO_BITS + 1;

	// record handed from one square-root cell to the next
	typedef struct packed {
		logic [ROOT_BITS+1:0]                  rem;
		logic [ROOT_BITS-1:0]                  root;
		logic [SUM_WIDTH-1:0]                  rad;
		logic [LANES-1:0][COMP_WIDTH-1:0]      mag;
		logic [LANES-1:0]                      neg;
	} sq_t;

	// record handed from one divider cell to the next
	typedef struct packed {
		logic [ROOT_BITS-1:0]                  len;
		logic [LANES-1:0][ROOT_BITS-1:0]       rem;
		logic [LANES-1:0][QUO_BITS-1:0]        quo;
		logic [LANES-1:0]                      lsb;
		logic [LANES-1:0]                      neg;
	} dv_t;

endpackage

// File: rtl/core/v3n_sqrt_cell.sv
// One digit cell of the pipelined square root: resolves one root bit.
// Depends on v3n_pkg.
module v3n_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  v3n_pkg::sq_t   din,
	output v3n_pkg::sq_t   dout
);

	logic [v3n_pkg::ROOT_BITS+3:0] cur;
	logic [v3n_pkg::ROOT_BITS+3:0] trial;
	logic [v3n_pkg::ROOT_BITS+3:0] diff;
	logic                          take;

	always_comb begin
		cur   = {din.rem, din.rad[v3n_pkg::SUM_WIDTH-1 -: 2]};
		trial = {2'b00, din.root, 2'b01};
		take  = (cur >= trial);
		diff  = cur - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem  <= take ? diff[v3n_pkg::ROOT_BITS+1:0] : cur[v3n_pkg::ROOT_BITS+1:0];
			dout.root <= {din.root[v3n_pkg::ROOT_BITS-2:0], take};
			dout.rad  <= {din.rad[v3n_pkg::SUM_WIDTH-3:0], 2'b00};
			dout.mag  <= din.mag;
			dout.neg  <= din.neg;
		end
	end

endmodule

// File: rtl/core/v3n_div_cell.sv
// One restoring-division cell: resolves one quotient bit on all three lanes.
// Depends on v3n_pkg.
module v3n_div_cell (
	input  logic           clk,
	input  logic           en,
	input  v3n_pkg::dv_t   din,
	output v3n_pkg::dv_t   dout
);

	logic [v3n_pkg::LANES-1:0][v3n_pkg::ROOT_BITS:0] part;
	logic [v3n_pkg::LANES-1:0][v3n_pkg::ROOT_BITS:0] diff;
	logic [v3n_pkg::LANES-1:0]                       take;

	always_comb begin
		for (int i = 0; i < v3n_pkg::LANES; i++) begin
			part[i] = {din.rem[i], din.lsb[i]};
			take[i] = (part[i] >= {1'b0, din.len});
			diff[i] = part[i] - {1'b0, din.len};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < v3n_pkg::LANES; i++) begin
				dout.rem[i] <= take[i] ? diff[i][v3n_pkg::ROOT_BITS-1:0]
				                       : part[i][v3n_pkg::ROOT_BITS-1:0];
				dout.quo[i] <= {din.quo[i][v3n_pkg::QUO_BITS-2:0], take[i]};
			end
			dout.lsb <= '0; // only the first cell shifts in a dividend bit
			dout.len <= din.len;
			dout.neg <= din.neg;
		end
	end

endmodule

// File: rtl/core/vec3_normalize.sv
// Top level of vec3_normalize: abs/square/sum front end, square-root cell row,
// divider cell row and output register. Depends on v3n_pkg and both cell modules.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one transaction per vector:
//    vec_x, vec_y, vec_z in signed Q16.16.
//  - Output channel (out_valid/out_ready) returns one transaction per input:
//    unit_x/y/z in signed Q2.30, magnitude in unsigned Q17.16 (floored root),
//    zero_length set when all components are zero (unit vector forced to 0).
//  - Pipeline: there are 67 register stages (3 front-end, 32 square-root
//    cells, 31 divider cells, 1 output register); the first one loads at
//    the accepting edge itself.
//  - Throughput: one vector per cycle while the pipe is not stalled; every
//    cell row is fully pipelined, one root bit or one quotient bit per cell.
//  - Stall: the whole pipe holds while a result sits in the output register
//    and out_ready is low; in_ready drops for those cycles only. A transaction
//    is still taken in the cycle the waiting result leaves.
//  - Reset (arst_n low) clears all stage valid bits; in-flight vectors are
//    dropped. No configuration and no state between vectors.
module vec3_normalize (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	input  logic [31:0] vec_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] unit_x,
	output logic [31:0] unit_y,
	output logic [31:0] unit_z,
	output logic [32:0] magnitude,
	output logic        zero_length
);

	localparam int CW = v3n_pkg::COMP_WIDTH;
	localparam int NL = v3n_pkg::LANES;

	logic en;
	logic [v3n_pkg::PIPE_DEPTH-1:0] vld_q;

	// pipe advances unless the output register holds an untaken result
	assign en       = !(out_valid && !out_ready);
	assign in_ready = en;
	assign out_valid = vld_q[v3n_pkg::PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[v3n_pkg::PIPE_DEPTH-2:0], in_valid};
		end
	end

	// stage 1: magnitude and sign of each component
	logic [NL-1:0][CW-1:0] raw;
	logic [NL-1:0][CW-1:0] mag_s1;
	logic [NL-1:0]         neg_s1;
	assign raw[0] = vec_x;
	assign raw[1] = vec_y;
	assign raw[2] = vec_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++) begin
				neg_s1[i] <= raw[i][CW-1];
				mag_s1[i] <= raw[i][CW-1] ? (~raw[i] + 1'b1) : raw[i];
			end
		end
	end

	// stage 2: squares
	logic [NL-1:0][2*CW-1:0] sq_s2;
	logic [NL-1:0][CW-1:0]   mag_s2;
	logic [NL-1:0]           neg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++) begin
				sq_s2[i] <= (2*CW)'(mag_s1[i]) * (2*CW)'(mag_s1[i]);
			end
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: sum of squares (fits 64 bits: three terms of at most 2^62 each)
	v3n_pkg::sq_t sq_row [0:v3n_pkg::ROOT_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_row[0].rad  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sq_row[0].rem  <= '0;
			sq_row[0].root <= '0;
			sq_row[0].mag  <= mag_s2;
			sq_row[0].neg  <= neg_s2;
		end
	end

	// square-root row: one root bit per cell, MSB first
	for (genvar k = 0; k < v3n_pkg::ROOT_BITS; k++) begin : g_sqrt
		v3n_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (sq_row[k]),
			.dout (sq_row[k+1])
		);
	end

	// divider row: quotient = mag * 2^30 / len; initial remainder mag >> 1
	// is below len since the floored length is never under any component
	v3n_pkg::dv_t dv_row [0:v3n_pkg::QUO_BITS];
	v3n_pkg::sq_t sq_end;
	assign sq_end = sq_row[v3n_pkg::ROOT_BITS];

	always_comb begin
		dv_row[0].len = sq_end.root;
		dv_row[0].neg = sq_end.neg;
		for (int i = 0; i < NL; i++) begin
			dv_row[0].rem[i] = {1'b0, sq_end.mag[i][CW-1:1]};
			dv_row[0].lsb[i] = sq_end.mag[i][0];
			dv_row[0].quo[i] = '0;
		end
	end

	for (genvar k = 0; k < v3n_pkg::QUO_BITS; k++) begin : g_div
		v3n_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (dv_row[k]),
			.dout (dv_row[k+1])
		);
	end

	// output register: sign restore and zero-length override
	v3n_pkg::dv_t dv_end;
	logic         zero_len;
	logic [NL-1:0][31:0] unit_d;
	logic [NL-1:0][31:0] unit_q;
	logic [32:0]         mag_q;
	logic                zero_q;

	assign dv_end   = dv_row[v3n_pkg::QUO_BITS];
	assign zero_len = (dv_end.len == '0);

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			if (zero_len) begin
				unit_d[i] = '0;
			end else if (dv_end.neg[i]) begin
				unit_d[i] = ~{1'b0, dv_end.quo[i]} + 1'b1;
			end else begin
				unit_d[i] = {1'b0, dv_end.quo[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_q <= unit_d;
			mag_q  <= {1'b0, dv_end.len};
			zero_q <= zero_len;
		end
	end

	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign magnitude   = mag_q;
	assign zero_length = zero_q;

	// zero flag goes with zero length and a zero unit vector
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> magnitude == '0 && unit_x == '0 &&
		unit_y == '0 && unit_z == '0)
		else $error("zero_length with nonzero result");

	a_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_length |-> magnitude != '0)
		else $error("zero magnitude without zero_length");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(unit_x) <= 32'sd1073741824) &&
		($signed(unit_x) >= -32'sd1073741824))
		else $error("unit_x out of range");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !(out_valid && !out_ready))
		else $error("in_ready does not follow output stall");

endmodule
